/* rtl/slfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_pkg: shared definitions for the sync/length frame extractor
// Sizes, protocol bytes, sequencer states, result item type and helpers.
// ----------------------------------------------------------------------------
package slfe_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int MAX_FRAME   = 40;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = 9;
    localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam int HDR_LEN     = 13;
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);
    localparam int SYNC_LEN    = 3;
    localparam int LEN_BIAS    = 12;
    localparam int REJECT_DROP = 5;

    localparam int OFS_MAIN    = 3;
    localparam int OFS_MINOR   = 4;
    localparam int OFS_LISTEN  = 5;
    localparam int OFS_CMD     = 8;
    localparam int OFS_LEN     = 9;
    localparam int OFS_TRL_HI  = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] SYNC_BYTE   = 8'hCC;
    localparam logic [7:0] TRL_HI      = 8'h45;
    localparam logic [7:0] TRL_LO      = 8'h5A;
    localparam logic [7:0] LISTEN_BYTE = 8'h54;
    localparam logic [7:0] CMD_READ    = 8'h52;
    localparam logic [7:0] CMD_QUERY   = 8'h51;

    localparam logic [1:0] CLS_LISTEN  = 2'd0;
    localparam logic [1:0] CLS_TALK    = 2'd1;
    localparam logic [1:0] CLS_QUERY   = 2'd2;
    localparam logic [1:0] CLS_OTHER   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDR_RD,
        ST_HDR_CHK,
        ST_LEN,
        ST_TRL_RD,
        ST_TRL_HI,
        ST_TRL_LO,
        ST_EMIT_RD,
        ST_EMIT_PUSH
    } slfe_state_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [7:0] main_address;
        logic [7:0] minor_address;
        logic       listen_flag;
        logic [1:0] command_class;
    } slfe_item_t;

    // circular buffer address: base + off, off <= STORE_DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(STORE_DEPTH))
            sum = sum - (CNT_W + 1)'(STORE_DEPTH);
        return ADDR_W'(sum);
    endfunction

    function automatic logic [1:0] cmd_class(input logic [7:0] cmd, input logic listen);
        logic [1:0] cls;
        if (cmd == CMD_READ)
            cls = listen ? CLS_LISTEN : CLS_TALK;
        else if (cmd == CMD_QUERY)
            cls = CLS_QUERY;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

endpackage
`default_nettype wire

/* rtl/slfe_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_front: byte buffer and frame scanner
// Circular byte store with one registered read port. A sequencer syncs on
// CC CC CC, checks length and trailer, and pushes accepted frame bytes.
// ----------------------------------------------------------------------------
module slfe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output slfe_pkg::slfe_item_t    push_item
);

    logic [7:0] mem [slfe_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic [slfe_pkg::ADDR_W-1:0] rd_addr;
    logic [slfe_pkg::ADDR_W-1:0] wr_addr;
    logic mem_we;

    slfe_pkg::slfe_state_t state_reg, state_next;
    logic [slfe_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [slfe_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [slfe_pkg::HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic                           hdr_valid_reg, hdr_valid_next;
    logic                           ok13_reg, ok13_next;
    logic [slfe_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                           trl_hi_ok_reg, trl_hi_ok_next;
    logic [slfe_pkg::CNT_W-1:0]     emit_idx_reg, emit_idx_next;

    logic [7:0] main_reg;
    logic [7:0] minor_reg;
    logic       listen_reg;
    logic [7:0] cmd_reg;
    logic [7:0] len_byte_reg;
    logic [7:0] trl_byte_reg;

    logic full;
    logic do_reject;
    logic do_emit;
    logic emit_last;

    assign full      = (fill_reg == slfe_pkg::CNT_W'(slfe_pkg::STORE_DEPTH));
    assign wr_addr   = slfe_pkg::wrap_add(head_reg, full ? '0 : fill_reg);
    assign in_ready  = (state_reg == slfe_pkg::ST_IDLE);
    assign mem_we    = in_valid && in_ready;
    assign emit_last = (slfe_pkg::LEN_W'(emit_idx_reg) == len_reg - slfe_pkg::LEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= rx_byte;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == slfe_pkg::ST_HDR_CHK)
        begin
            case (hdr_idx_reg)
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_MAIN):   main_reg     <= rd_data_reg;
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_MINOR):  minor_reg    <= rd_data_reg;
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_LISTEN):
                    listen_reg <= (rd_data_reg == slfe_pkg::LISTEN_BYTE);
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_CMD):    cmd_reg      <= rd_data_reg;
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_LEN):    len_byte_reg <= rd_data_reg;
                slfe_pkg::HDR_IDX_W'(slfe_pkg::OFS_TRL_HI): trl_byte_reg <= rd_data_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slfe_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            hdr_idx_reg   <= '0;
            hdr_valid_reg <= 1'b0;
            ok13_reg      <= 1'b0;
            len_reg       <= '0;
            trl_hi_ok_reg <= 1'b0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            hdr_idx_reg   <= hdr_idx_next;
            hdr_valid_reg <= hdr_valid_next;
            ok13_reg      <= ok13_next;
            len_reg       <= len_next;
            trl_hi_ok_reg <= trl_hi_ok_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_valid_next = hdr_valid_reg;
        ok13_next      = ok13_reg;
        len_next       = len_reg;
        trl_hi_ok_next = trl_hi_ok_reg;
        emit_idx_next  = emit_idx_reg;
        rd_addr        = head_reg;
        push_valid     = 1'b0;
        do_reject      = 1'b0;
        do_emit        = 1'b0;

        unique case (state_reg)
            slfe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // full store: oldest byte is overwritten
                    if (full)
                    begin
                        head_next      = slfe_pkg::wrap_add(head_reg, slfe_pkg::CNT_W'(1));
                        hdr_valid_next = 1'b0;
                    end
                    else
                        fill_next = fill_reg + slfe_pkg::CNT_W'(1);
                    state_next = slfe_pkg::ST_SCAN;
                end
            end
            slfe_pkg::ST_SCAN:
            begin
                if (fill_reg < slfe_pkg::CNT_W'(slfe_pkg::HDR_LEN))
                    state_next = slfe_pkg::ST_IDLE;
                else if (hdr_valid_reg)
                    state_next = slfe_pkg::ST_LEN;
                else
                begin
                    hdr_idx_next = '0;
                    state_next   = slfe_pkg::ST_HDR_RD;
                end
            end
            slfe_pkg::ST_HDR_RD:
            begin
                rd_addr    = slfe_pkg::wrap_add(head_reg, slfe_pkg::CNT_W'(hdr_idx_reg));
                state_next = slfe_pkg::ST_HDR_CHK;
            end
            slfe_pkg::ST_HDR_CHK:
            begin
                if (hdr_idx_reg < slfe_pkg::HDR_IDX_W'(slfe_pkg::SYNC_LEN)
                    && rd_data_reg != slfe_pkg::SYNC_BYTE)
                begin
                    head_next  = slfe_pkg::wrap_add(head_reg, slfe_pkg::CNT_W'(1));
                    fill_next  = fill_reg - slfe_pkg::CNT_W'(1);
                    state_next = slfe_pkg::ST_SCAN;
                end
                else if (hdr_idx_reg == slfe_pkg::HDR_IDX_W'(slfe_pkg::HDR_LEN - 1))
                begin
                    hdr_valid_next = 1'b1;
                    ok13_next = (trl_byte_reg == slfe_pkg::TRL_HI)
                                && (rd_data_reg == slfe_pkg::TRL_LO);
                    if (ok13_next)
                        len_next = slfe_pkg::LEN_W'(slfe_pkg::HDR_LEN);
                    else
                        len_next = slfe_pkg::LEN_W'(len_byte_reg)
                                   + slfe_pkg::LEN_W'(slfe_pkg::LEN_BIAS);
                    state_next = slfe_pkg::ST_LEN;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + slfe_pkg::HDR_IDX_W'(1);
                    state_next   = slfe_pkg::ST_HDR_RD;
                end
            end
            slfe_pkg::ST_LEN:
            begin
                if (ok13_reg)
                    do_emit = 1'b1;
                else if (len_reg > slfe_pkg::LEN_W'(slfe_pkg::MAX_FRAME))
                    do_reject = 1'b1;
                else if (slfe_pkg::CMP_W'(fill_reg) < slfe_pkg::CMP_W'(len_reg))
                    state_next = slfe_pkg::ST_IDLE;
                else
                    state_next = slfe_pkg::ST_TRL_RD;
            end
            slfe_pkg::ST_TRL_RD:
            begin
                rd_addr = slfe_pkg::wrap_add(head_reg,
                              slfe_pkg::CNT_W'(len_reg - slfe_pkg::LEN_W'(2)));
                state_next = slfe_pkg::ST_TRL_HI;
            end
            slfe_pkg::ST_TRL_HI:
            begin
                trl_hi_ok_next = (rd_data_reg == slfe_pkg::TRL_HI);
                rd_addr = slfe_pkg::wrap_add(head_reg,
                              slfe_pkg::CNT_W'(len_reg - slfe_pkg::LEN_W'(1)));
                state_next = slfe_pkg::ST_TRL_LO;
            end
            slfe_pkg::ST_TRL_LO:
            begin
                if (trl_hi_ok_reg && rd_data_reg == slfe_pkg::TRL_LO)
                    do_emit = 1'b1;
                else
                    do_reject = 1'b1;
            end
            slfe_pkg::ST_EMIT_RD:
            begin
                rd_addr    = slfe_pkg::wrap_add(head_reg, emit_idx_reg);
                state_next = slfe_pkg::ST_EMIT_PUSH;
            end
            slfe_pkg::ST_EMIT_PUSH:
            begin
                // hold the read address so the data survives a stall
                rd_addr    = slfe_pkg::wrap_add(head_reg, emit_idx_reg);
                push_valid = 1'b1;
                if (push_ready)
                begin
                    if (emit_last)
                    begin
                        head_next = slfe_pkg::wrap_add(head_reg,
                                        slfe_pkg::CNT_W'(len_reg));
                        fill_next      = fill_reg - slfe_pkg::CNT_W'(len_reg);
                        hdr_valid_next = 1'b0;
                        state_next     = slfe_pkg::ST_SCAN;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + slfe_pkg::CNT_W'(1);
                        state_next    = slfe_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
                state_next = slfe_pkg::ST_IDLE;
        endcase

        if (do_reject)
        begin
            head_next = slfe_pkg::wrap_add(head_reg, slfe_pkg::CNT_W'(slfe_pkg::REJECT_DROP));
            fill_next      = fill_reg - slfe_pkg::CNT_W'(slfe_pkg::REJECT_DROP);
            hdr_valid_next = 1'b0;
            state_next     = slfe_pkg::ST_SCAN;
        end
        if (do_emit)
        begin
            emit_idx_next = '0;
            state_next    = slfe_pkg::ST_EMIT_RD;
        end
    end

    always_comb
    begin
        push_item.frame_byte    = rd_data_reg;
        push_item.frame_last    = emit_last;
        push_item.main_address  = main_reg;
        push_item.minor_address = minor_reg;
        push_item.listen_flag   = listen_reg;
        push_item.command_class = slfe_pkg::cmd_class(cmd_reg, listen_reg);
    end

endmodule
`default_nettype wire

/* rtl/slfe_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_queue: result queue
// Short FIFO between the scanner and the output channel.
// ----------------------------------------------------------------------------
module slfe_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire slfe_pkg::slfe_item_t push_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output slfe_pkg::slfe_item_t      out_item
);

    slfe_pkg::slfe_item_t entries [slfe_pkg::QUEUE_DEPTH];
    logic [slfe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [slfe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [slfe_pkg::QPTR_W:0]   count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != (slfe_pkg::QPTR_W + 1)'(slfe_pkg::QUEUE_DEPTH));
    assign out_valid  = (count_reg != '0);
    assign out_item   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + slfe_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + slfe_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (slfe_pkg::QPTR_W + 1)'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - (slfe_pkg::QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/sync_length_frame_extractor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_frame_extractor: serial byte deframer
// Input channel in_valid/in_ready carries one received byte per transfer.
// Output channel out_valid/out_ready carries one frame byte per transfer,
// with frame_last on the final byte and the frame's address and command
// fields repeated on every byte.
// Each byte goes into the store; the scanner idles again when the store holds
// fewer than 13 bytes, rechecks the length while a checked header waits for
// the rest of its frame, drops a stray byte in front of the sync pattern, or
// fetches a 13-byte header through the single read port of the 64-byte store,
// one read per header byte; a rejected frame adds a rescan of the bytes
// behind it. Frame bytes leave by one store read and one queue push each.
// Reset empties the store and the result queue; the store needs no clear.
// A stalled receiver fills the 4-entry result queue, the scanner then
// holds, and in_ready stays low until the frame is fully queued.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      frame_byte,
    output logic            frame_last,
    output logic [7:0]      main_address,
    output logic [7:0]      minor_address,
    output logic            listen_flag,
    output logic [1:0]      command_class
);

    logic                 push_valid;
    logic                 push_ready;
    slfe_pkg::slfe_item_t push_item;
    slfe_pkg::slfe_item_t out_item;

    slfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    slfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    assign frame_byte    = out_item.frame_byte;
    assign frame_last    = out_item.frame_last;
    assign main_address  = out_item.main_address;
    assign minor_address = out_item.minor_address;
    assign listen_flag   = out_item.listen_flag;
    assign command_class = out_item.command_class;

endmodule
`default_nettype wire

/* rtl/slfe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_checker: port-level checks for the frame extractor
// Output hold under stall, per-frame field consistency, command class rules.
// ----------------------------------------------------------------------------
module slfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] frame_byte,
    input wire logic       frame_last,
    input wire logic [7:0] main_address,
    input wire logic [7:0] minor_address,
    input wire logic       listen_flag,
    input wire logic [1:0] command_class
);

    logic       mid_frame_reg;
    logic [7:0] main_prev_reg;
    logic [7:0] minor_prev_reg;
    logic       xfer;

    assign xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_frame_reg <= 1'b0;
        else if (xfer)
            mid_frame_reg <= !frame_last;
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            main_prev_reg  <= main_address;
            minor_prev_reg <= minor_address;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_last))
        else $error("output transfer changed while stalled");

    a_frame_addr: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && mid_frame_reg |->
            main_address == main_prev_reg && minor_address == minor_prev_reg)
        else $error("address fields changed inside a frame");

    a_listen_cls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_class == slfe_pkg::CLS_LISTEN |-> listen_flag)
        else $error("listen class without listen flag");

    a_talk_cls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && listen_flag |-> command_class != slfe_pkg::CLS_TALK)
        else $error("talk class with listen flag set");

endmodule

bind sync_length_frame_extractor slfe_checker u_slfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .frame_last    (frame_last),
    .main_address  (main_address),
    .minor_address (minor_address),
    .listen_flag   (listen_flag),
    .command_class (command_class)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sync_length_frame_extractor
// Feeds framed, corrupted and noisy byte streams through the input channel
// under random gaps and receiver stalls, including one long output hold.
// A byte-level model of the deframer predicts every emitted frame byte, and
// each output transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RESULT_CAP   = 64;
    localparam int LONGEST_BODY = slfe_pkg::MAX_FRAME - slfe_pkg::LEN_BIAS;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef enum {FR_SHORT, FR_LONG, FR_BAD_TRAILER, FR_OVERLONG, FR_NOISE} frame_kind_t;

    class frame_scoreboard_t;
        bit [7:0]             held[$];
        slfe_pkg::slfe_item_t pending[$];
        int                   errors = 0;

        function void drop_held(int n);
            int i;
            for (i = 0; i < n; i++)
                if (held.size() > 0)
                    void'(held.pop_front());
        endfunction

        // receive one byte and predict every frame byte it releases
        function void note_byte(bit [7:0] b);
            int                   emitted;
            int                   flen;
            int                   i;
            bit                   done;
            bit                   listen;
            bit [1:0]             cls;
            slfe_pkg::slfe_item_t item;
            emitted = 0;
            done    = 1'b0;
            if (held.size() >= slfe_pkg::STORE_DEPTH)
                drop_held(1);
            held.push_back(b);
            while (!done)
            begin
                while (held.size() >= slfe_pkg::HDR_LEN &&
                       !(held[0] == slfe_pkg::SYNC_BYTE && held[1] == slfe_pkg::SYNC_BYTE &&
                         held[2] == slfe_pkg::SYNC_BYTE))
                    drop_held(1);
                if (held.size() < slfe_pkg::HDR_LEN)
                begin
                    done = 1'b1;
                end
                else
                begin
                    if (held[slfe_pkg::OFS_TRL_HI] == slfe_pkg::TRL_HI &&
                        held[slfe_pkg::OFS_TRL_HI + 1] == slfe_pkg::TRL_LO)
                    begin
                        flen = slfe_pkg::HDR_LEN;
                    end
                    else
                    begin
                        flen = int'(held[slfe_pkg::OFS_LEN]) + slfe_pkg::LEN_BIAS;
                        if (flen > slfe_pkg::MAX_FRAME)
                            flen = -1;
                        else if (held.size() < flen)
                            flen = 0;
                        else if (!(held[flen - 2] == slfe_pkg::TRL_HI &&
                                   held[flen - 1] == slfe_pkg::TRL_LO))
                            flen = -1;
                    end
                    if (flen == 0)
                    begin
                        done = 1'b1;
                    end
                    else if (flen < 0)
                    begin
                        drop_held(slfe_pkg::REJECT_DROP);
                    end
                    else if (emitted + flen > RESULT_CAP)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        listen = (held[slfe_pkg::OFS_LISTEN] == slfe_pkg::LISTEN_BYTE);
                        if (held[slfe_pkg::OFS_CMD] == slfe_pkg::CMD_READ)
                            cls = listen ? slfe_pkg::CLS_LISTEN : slfe_pkg::CLS_TALK;
                        else if (held[slfe_pkg::OFS_CMD] == slfe_pkg::CMD_QUERY)
                            cls = slfe_pkg::CLS_QUERY;
                        else
                            cls = slfe_pkg::CLS_OTHER;
                        for (i = 0; i < flen; i++)
                        begin
                            item.frame_byte    = held[i];
                            item.frame_last    = (i == flen - 1);
                            item.main_address  = held[slfe_pkg::OFS_MAIN];
                            item.minor_address = held[slfe_pkg::OFS_MINOR];
                            item.listen_flag   = listen;
                            item.command_class = cls;
                            pending.push_back(item);
                        end
                        emitted += flen;
                        drop_held(flen);
                    end
                end
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_item(slfe_pkg::slfe_item_t got);
            slfe_pkg::slfe_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transfer, frame_byte expected none actual %0h",
                         $time, got.frame_byte);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                check_field("frame_byte", want.frame_byte, got.frame_byte);
                check_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
                check_field("main_address", want.main_address, got.main_address);
                check_field("minor_address", want.minor_address, got.minor_address);
                check_field("listen_flag", 8'(want.listen_flag), 8'(got.listen_flag));
                check_field("command_class", 8'(want.command_class),
                            8'(got.command_class));
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [7:0] main_address;
    logic [7:0] minor_address;
    logic       listen_flag;
    logic [1:0] command_class;

    slfe_pkg::slfe_item_t rx_item;
    frame_scoreboard_t    sb = new;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 hold_rx = 1'b0;
    int                   sent_bytes = 0;
    int                   stall_cycles = 0;

    assign rx_item = {frame_byte, frame_last, main_address, minor_address,
                      listen_flag, command_class};

    sync_length_frame_extractor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .frame_last    (frame_last),
        .main_address  (main_address),
        .minor_address (minor_address),
        .listen_flag   (listen_flag),
        .command_class (command_class)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_item(rx_item);
        out_ready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input bit [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    // n: body length (byte 9) for length frames, byte count for noise
    task automatic send_frame(input frame_kind_t kind, input int n,
                              input bit [7:0] cmd, input bit listen);
        bit [7:0] fb[$];
        int       flen;
        int       i;
        if (kind == FR_NOISE)
        begin
            for (i = 0; i < n; i++)
                fb.push_back(8'($urandom()));
        end
        else
        begin
            for (i = 0; i < slfe_pkg::SYNC_LEN; i++)
                fb.push_back(slfe_pkg::SYNC_BYTE);
            for (i = slfe_pkg::SYNC_LEN; i < slfe_pkg::HDR_LEN; i++)
                fb.push_back(8'($urandom()));
            if (listen)
                fb[slfe_pkg::OFS_LISTEN] = slfe_pkg::LISTEN_BYTE;
            else if (fb[slfe_pkg::OFS_LISTEN] == slfe_pkg::LISTEN_BYTE)
                fb[slfe_pkg::OFS_LISTEN] ^= 8'h01;
            fb[slfe_pkg::OFS_CMD] = cmd;
            if (kind == FR_SHORT)
            begin
                fb[slfe_pkg::OFS_TRL_HI]     = slfe_pkg::TRL_HI;
                fb[slfe_pkg::OFS_TRL_HI + 1] = slfe_pkg::TRL_LO;
            end
            else
            begin
                fb[slfe_pkg::OFS_LEN] = 8'(n);
                if (fb[slfe_pkg::OFS_TRL_HI] == slfe_pkg::TRL_HI &&
                    fb[slfe_pkg::OFS_TRL_HI + 1] == slfe_pkg::TRL_LO)
                    fb[slfe_pkg::OFS_TRL_HI + 1] ^= 8'h01;
                if (kind != FR_OVERLONG)
                begin
                    flen = n + slfe_pkg::LEN_BIAS;
                    while (fb.size() > flen)
                        void'(fb.pop_back());
                    while (fb.size() < flen)
                        fb.push_back(8'($urandom()));
                    fb[flen - 2] = slfe_pkg::TRL_HI;
                    fb[flen - 1] = (kind == FR_BAD_TRAILER) ?
                                   (slfe_pkg::TRL_LO ^ 8'h01) : slfe_pkg::TRL_LO;
                end
            end
        end
        foreach (fb[k])
            send_byte(fb[k]);
    endtask

    task automatic random_frame();
        int          pick;
        int          n;
        bit [7:0]    cmd;
        frame_kind_t kind;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       cmd = slfe_pkg::CMD_READ;
            1:       cmd = slfe_pkg::CMD_QUERY;
            default: cmd = 8'($urandom());
        endcase
        if (pick < 45)
        begin
            kind = FR_LONG;
        end
        else if (pick < 70)
        begin
            kind = FR_SHORT;
        end
        else if (pick < 80)
        begin
            kind = FR_BAD_TRAILER;
        end
        else if (pick < 90)
        begin
            kind = FR_OVERLONG;
        end
        else
        begin
            kind = FR_NOISE;
        end
        case (kind)
            FR_OVERLONG: n = $urandom_range(LONGEST_BODY + 1, 255);
            FR_NOISE:    n = $urandom_range(1, 6);
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    n = LONGEST_BODY;
                else if (pick < 7)
                    n = $urandom_range(0, 4);
                else
                    n = $urandom_range(0, LONGEST_BODY);
            end
        endcase
        send_frame(kind, n, cmd, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct <= 48;
        send_frame(FR_SHORT, 0, slfe_pkg::CMD_READ, 1'b1);
        send_frame(FR_LONG, 0, slfe_pkg::CMD_READ, 1'b0);
        send_frame(FR_OVERLONG, 255, 8'h00, 1'b0);
        send_frame(FR_SHORT, 0, slfe_pkg::CMD_QUERY, 1'b0);
        send_frame(FR_LONG, LONGEST_BODY, 8'hFF, 1'b1);
        send_frame(FR_BAD_TRAILER, 3, slfe_pkg::CMD_READ, 1'b1);
        while (sent_bytes < 140)
            random_frame();

        send_idle_pct = 48;
        recv_idle_pct <= 11;
        while (sent_bytes < 250)
            random_frame();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
            begin
                repeat (3) send_frame(FR_LONG, LONGEST_BODY, slfe_pkg::CMD_QUERY, 1'b0);
            end
        join
        while (sent_bytes < 350)
            random_frame();
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sync_length_frame_extractor.f */
rtl/slfe_pkg.sv
rtl/slfe_front.sv
rtl/slfe_queue.sv
rtl/sync_length_frame_extractor.sv
rtl/slfe_checker.sv
tb/tb_top.sv
